FILE: sv/button_click_long_press_detector_assert.svh
// ---------------------------------------------------------------------------
// button click / long-press detector assertion macros
// shared property shapes for the concurrent checks in the rtl
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BCLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define BCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: sv/bcld_pkg.sv
// ---------------------------------------------------------------------------
// bcld_pkg
// types and constants shared by the button click / long-press detector
// ---------------------------------------------------------------------------
package bcld_pkg;

    localparam int NOW_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MS_W        = 16;
    localparam int LPS_W       = 8;
    localparam int CLICK_W     = 8;
    localparam int HELD_W      = 16;
    localparam int LONG_MS_W   = 18;
    localparam int MS_PER_SEC  = 1000;

    localparam logic [MS_W-1:0]  RST_PRESS_DEB = 16'd10;
    localparam logic [MS_W-1:0]  RST_CLICK_WIN = 16'd500;
    localparam logic [LPS_W-1:0] RST_LONG_SEC  = 8'd3;
    localparam logic [MS_W-1:0]  RST_LONG_REP  = 16'd1000;
    localparam logic [MS_W-1:0]  RST_REL_DEB   = 16'd100;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PDEB     = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_RDEB     = 3'd3,
        PH_RELEASED = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_RELEASED = 2'd1,
        EV_LONG     = 2'd2,
        EV_RUN_END  = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_DEB = 3'd0,
        CFG_CLICK_WIN = 3'd1,
        CFG_LONG_SEC  = 3'd2,
        CFG_LONG_REP  = 3'd3,
        CFG_REL_DEB   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             pressed;
    } t_in;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [CLICK_W-1:0] click_total;
        logic [HELD_W-1:0]  held_seconds;
    } t_out;

    typedef struct packed {
        logic [MS_W-1:0]  press_debounce_ms;
        logic [MS_W-1:0]  click_window_ms;
        logic [LPS_W-1:0] long_press_seconds;
        logic [MS_W-1:0]  long_repeat_ms;
        logic [MS_W-1:0]  release_debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_evt;

endpackage

FILE: sv/bcld_cfg.sv
// ---------------------------------------------------------------------------
// bcld_cfg
// configuration register bank, written one register per transaction
// ---------------------------------------------------------------------------
module bcld_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic [bcld_pkg::CFG_IDX_W-1:0]      i_index,
    input  logic [bcld_pkg::CFG_DATA_W-1:0]     i_data,
    output bcld_pkg::t_cfg                      o_cfg
);

    bcld_pkg::t_cfg r_cfg;
    bcld_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                bcld_pkg::CFG_PRESS_DEB: n_cfg.press_debounce_ms   = i_data;
                bcld_pkg::CFG_CLICK_WIN: n_cfg.click_window_ms     = i_data;
                bcld_pkg::CFG_LONG_SEC:
                    n_cfg.long_press_seconds = i_data[bcld_pkg::LPS_W-1:0];
                bcld_pkg::CFG_LONG_REP:  n_cfg.long_repeat_ms      = i_data;
                bcld_pkg::CFG_REL_DEB:   n_cfg.release_debounce_ms = i_data;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_debounce_ms   <= bcld_pkg::RST_PRESS_DEB;
            r_cfg.click_window_ms     <= bcld_pkg::RST_CLICK_WIN;
            r_cfg.long_press_seconds  <= bcld_pkg::RST_LONG_SEC;
            r_cfg.long_repeat_ms      <= bcld_pkg::RST_LONG_REP;
            r_cfg.release_debounce_ms <= bcld_pkg::RST_REL_DEB;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/bcld_fsm.sv
// ---------------------------------------------------------------------------
// bcld_fsm
// five-phase button state machine with deadline and count registers
// ---------------------------------------------------------------------------
`include "button_click_long_press_detector_assert.svh"

module bcld_fsm #(
    parameter int TIME_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  bcld_pkg::t_in   i_sample,
    input  bcld_pkg::t_cfg  i_cfg,
    output bcld_pkg::t_evt  o_evt
);

    localparam int TW = TIME_WIDTH;

    bcld_pkg::t_phase r_phase;
    bcld_pkg::t_phase n_phase;
    logic [TW-1:0] r_step_dl, n_step_dl;
    logic [TW-1:0] r_long_dl, n_long_dl;
    logic [TW-1:0] r_click_dl, n_click_dl;
    logic [bcld_pkg::CLICK_W-1:0] r_click, n_click;
    logic [bcld_pkg::HELD_W-1:0]  r_held, n_held;

    logic [TW-1:0] now_t;
    logic          down;
    logic [bcld_pkg::LONG_MS_W-1:0] long_ms;
    logic [TW-1:0] sum_pdeb, sum_rdeb, sum_click, sum_long, sum_rep;
    logic [TW-1:0] diff_step, diff_long, diff_click;
    logic          past_step, past_long, past_click;
    logic [bcld_pkg::CLICK_W-1:0] click_inc;
    logic [bcld_pkg::HELD_W-1:0]  held_inc;
    logic [bcld_pkg::HELD_W-1:0]  held_first;

    assign now_t = TW'(i_sample.now_ms);
    assign down  = i_sample.pressed;

    assign long_ms = bcld_pkg::LONG_MS_W'(i_cfg.long_press_seconds)
                   * bcld_pkg::LONG_MS_W'(bcld_pkg::MS_PER_SEC);

    assign sum_pdeb  = now_t + TW'(i_cfg.press_debounce_ms);
    assign sum_rdeb  = now_t + TW'(i_cfg.release_debounce_ms);
    assign sum_click = now_t + TW'(i_cfg.click_window_ms);
    assign sum_long  = now_t + TW'(long_ms);
    assign sum_rep   = now_t + TW'(i_cfg.long_repeat_ms);

    // strictly after: deadline minus now is negative modulo the time width
    assign diff_step  = r_step_dl - now_t;
    assign diff_long  = r_long_dl - now_t;
    assign diff_click = r_click_dl - now_t;
    assign past_step  = diff_step[TW-1];
    assign past_long  = diff_long[TW-1];
    assign past_click = diff_click[TW-1];

    assign click_inc  = r_click + 1'b1;
    assign held_inc   = r_held + 1'b1;
    assign held_first = bcld_pkg::HELD_W'(i_cfg.long_press_seconds);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            unique case (r_phase)
                bcld_pkg::PH_PDEB: begin
                    if (!down) begin
                        n_phase = bcld_pkg::PH_IDLE;
                    end else if (past_step) begin
                        n_phase = bcld_pkg::PH_PRESSED;
                    end
                end
                bcld_pkg::PH_PRESSED: begin
                    if (!down) begin
                        n_phase = bcld_pkg::PH_RDEB;
                    end
                end
                bcld_pkg::PH_RDEB: begin
                    if (down) begin
                        n_phase = bcld_pkg::PH_PRESSED;
                    end else if (past_step) begin
                        n_phase = bcld_pkg::PH_RELEASED;
                    end
                end
                bcld_pkg::PH_RELEASED: n_phase = bcld_pkg::PH_IDLE;
                default: begin
                    n_phase = down ? bcld_pkg::PH_PDEB : bcld_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // datapath updates and event
    always_comb begin
        n_step_dl  = r_step_dl;
        n_long_dl  = r_long_dl;
        n_click_dl = r_click_dl;
        n_click    = r_click;
        n_held     = r_held;
        o_evt      = '0;
        if (i_step) begin
            unique case (r_phase)
                bcld_pkg::PH_PDEB: begin
                    if (down && past_step) begin
                        n_long_dl  = sum_long;
                        n_held     = '0;
                        n_click    = click_inc;
                        n_click_dl = sum_click;
                        o_evt.valid             = 1'b1;
                        o_evt.data.event_kind   = bcld_pkg::EV_PRESSED;
                        o_evt.data.click_total  = click_inc;
                    end
                end
                bcld_pkg::PH_PRESSED: begin
                    if (!down) begin
                        n_step_dl = sum_rdeb;
                    end else if (r_held == '0 && past_long) begin
                        n_held    = held_first;
                        n_click   = '0;
                        n_step_dl = sum_rep;
                        o_evt.valid             = 1'b1;
                        o_evt.data.event_kind   = bcld_pkg::EV_LONG;
                        o_evt.data.held_seconds = held_first;
                    end else if (r_held != '0 && past_step) begin
                        n_held    = held_inc;
                        n_step_dl = sum_rep;
                        o_evt.valid             = 1'b1;
                        o_evt.data.event_kind   = bcld_pkg::EV_LONG;
                        o_evt.data.held_seconds = held_inc;
                    end
                end
                bcld_pkg::PH_RDEB: begin
                    if (!down && past_step) begin
                        o_evt.valid             = 1'b1;
                        o_evt.data.event_kind   = bcld_pkg::EV_RELEASED;
                        o_evt.data.click_total  = r_click;
                        o_evt.data.held_seconds = r_held;
                    end
                end
                bcld_pkg::PH_RELEASED: ;
                default: begin
                    if (down) begin
                        n_step_dl = sum_pdeb;
                    end else if (r_click != '0 && past_click) begin
                        n_click = '0;
                        o_evt.valid            = 1'b1;
                        o_evt.data.event_kind  = bcld_pkg::EV_RUN_END;
                        o_evt.data.click_total = r_click;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= bcld_pkg::PH_IDLE;
            r_step_dl  <= '0;
            r_long_dl  <= '0;
            r_click_dl <= '0;
            r_click    <= '0;
            r_held     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_step_dl  <= n_step_dl;
            r_long_dl  <= n_long_dl;
            r_click_dl <= n_click_dl;
            r_click    <= n_click;
            r_held     <= n_held;
        end
    end

    `BCLD_ASSERT_NOW(a_evt_on_step, i_clk, i_rst_n, o_evt.valid, i_step)
    `BCLD_ASSERT_NEXT(a_released_to_idle, i_clk, i_rst_n, i_step && r_phase == bcld_pkg::PH_RELEASED, r_phase == bcld_pkg::PH_IDLE)
    `BCLD_ASSERT_NEXT(a_press_arms_hold, i_clk, i_rst_n, o_evt.valid && o_evt.data.event_kind == bcld_pkg::EV_PRESSED, r_phase == bcld_pkg::PH_PRESSED && r_held == '0)
    `BCLD_ASSERT_NEXT(a_run_end_clears, i_clk, i_rst_n, o_evt.valid && o_evt.data.event_kind == bcld_pkg::EV_RUN_END, r_click == '0 && r_phase == bcld_pkg::PH_IDLE)

endmodule

FILE: sv/bcld_out_stage.sv
// ---------------------------------------------------------------------------
// bcld_out_stage
// result register holding one event until the consumer takes it
// ---------------------------------------------------------------------------
module bcld_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bcld_pkg::t_evt  i_evt,
    input  logic            i_stall,
    output logic            o_valid,
    output bcld_pkg::t_out  o_data,
    output logic            o_busy
);

    logic           r_valid, n_valid;
    bcld_pkg::t_out r_data;

    // a new event only arrives when the register is free or draining
    always_comb begin
        n_valid = r_valid;
        if (i_evt.valid) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid) begin
            r_data <= i_evt.data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_busy  = r_valid && i_stall;

endmodule

FILE: sv/button_click_long_press_detector.sv
// ---------------------------------------------------------------------------
// button click / long-press detector
// Takes one sample (millisecond timestamp and button level) per transaction
// and debounces it through idle, press debounce, pressed, release debounce
// and released phases, reporting pressed, released, long-pressed and
// click-run-ended events, at most one per sample. A sample is registered on
// entry, and its state update and event land in the phase registers and the
// result register once the result register is not held by a stalling
// consumer. The phase, deadline and count registers update together, so a
// new sample is accepted every clock while no held result is stalled; input
// stall rises only while a sample waits behind a held result the consumer stalls.
// Configuration registers are written at any time through the cfg port,
// which is always ready, and should be changed only while the block is idle.
// ---------------------------------------------------------------------------
module button_click_long_press_detector #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bcld_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bcld_pkg::t_out                   o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bcld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bcld_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic           r_in_valid, n_in_valid;
    bcld_pkg::t_in  r_in;
    logic           out_busy;
    logic           step;
    bcld_pkg::t_cfg cfg;
    bcld_pkg::t_evt evt;

    assign o_cfg_ready = 1'b1;

    assign step       = r_in_valid && !out_busy;
    assign o_in_stall = r_in_valid && out_busy;
    assign n_in_valid = o_in_stall ? r_in_valid : i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    bcld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bcld_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sample (r_in),
        .i_cfg    (cfg),
        .o_evt    (evt)
    );

    bcld_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out),
        .o_busy  (out_busy)
    );

endmodule
